FILE: hdl/cl2n_pkg.sv
// Shared constants and types for the per-lane L2 norm block.
package cl2n_pkg;

  localparam int LANES    = 16;
  localparam int LANE_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 48;
  localparam int EPS_W    = 16;
  localparam int NORM_W   = 24;
  localparam int REM_W    = NORM_W + 3;
  localparam int STEP_W   = 5;

  localparam logic [EPS_W-1:0]  EPS_RESET = 16'd1;
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NORM_W - 1);

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_LOAD = 4'b0010,
    SQ_ITER = 4'b0100,
    SQ_DONE = 4'b1000
  } sq_state_t;

endpackage

FILE: hdl/cl2n_ifs.sv
// Channel interfaces: sample input, norm result and epsilon write.
interface cl2n_in_if import cl2n_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [LANE_W-1:0]          lane;
  logic                       last_of_channel;

  modport source (output valid, sample, lane, last_of_channel, input ready);
  modport sink   (input valid, sample, lane, last_of_channel, output ready);
endinterface

interface cl2n_out_if import cl2n_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] norm_lane;
  logic [NORM_W-1:0] norm_value;

  modport source (output valid, norm_lane, norm_value, input ready);
  modport sink   (input valid, norm_lane, norm_value, output ready);
endinterface

interface cl2n_cfg_if import cl2n_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/channel_l2_norm.sv
// Top level: per-lane sum of squares with a digit-serial square root on lane close.
//
// in_ch carries one signed Q7.8 sample per word with its lane and a
// last-of-channel flag. Each sample is squared and added (saturating at
// 2^48-1) to its lane's sum, held in a 16 x 48 RAM. Words without the
// flag are taken one per cycle while the root unit is idle; back-to-back
// words to the same lane are forwarded around the RAM read.
// A flagged word closes the lane: its sum plus epsilon goes to a square
// root unit that retires one result bit per cycle, and the lane is
// cleared. The result reaches out_ch through the root unit's load,
// iterate and done states; in_ch is held off from the cycle after that
// word until the root is handed to the output register.
// cfg_ch writes epsilon (Q.16), always ready; write it only while idle.
// Reset: all lane sums read as zero (per-lane valid bits), epsilon = 1.
// If out_ch stalls while the output register is full, the finished root
// waits in the root unit and in_ch stays closed until the register frees.
module channel_l2_norm import cl2n_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cl2n_in_if.sink     in_ch,
  cl2n_out_if.source  out_ch,
  cl2n_cfg_if.sink    cfg_ch
);

  // epsilon register
  logic [EPS_W-1:0] eps_r, eps_nxt;

  // accept stage
  logic              in_fire;
  logic [MAG_W-1:0]  mag;
  logic [2*MAG_W-1:0] prod;

  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_last_r;
  logic [LANE_W-1:0] s1_lane_r;
  logic [SQ_W-1:0]   s1_sq_r;

  // accumulate stage
  logic [SUM_W-1:0]  ram_rdata;
  logic [SUM_W-1:0]  old_sum;
  logic [SUM_W:0]    acc_wide;
  logic [SUM_W-1:0]  acc_sat;
  logic [SUM_W-1:0]  wr_data;
  logic [LANES-1:0]  lane_vld_r, lane_vld_nxt;
  logic              wb_vld_r, wb_vld_nxt;
  logic [LANE_W-1:0] wb_lane_r;
  logic [SUM_W-1:0]  wb_data_r;

  // square root unit
  sq_state_t         sq_state_r, sq_state_nxt;
  logic [SUM_W-1:0]  sq_x_r, sq_x_nxt;
  logic [LANE_W-1:0] sq_lane_r, sq_lane_nxt;
  logic [REM_W-1:0]  sq_rem_r, sq_rem_nxt;
  logic [NORM_W-1:0] sq_root_r, sq_root_nxt;
  logic [STEP_W-1:0] sq_cnt_r, sq_cnt_nxt;
  logic [SUM_W:0]    eps_wide;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // output register
  logic              out_vld_r, out_vld_nxt;
  logic [LANE_W-1:0] out_lane_r, out_lane_nxt;
  logic [NORM_W-1:0] out_norm_r, out_norm_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (sq_state_r == SQ_IDLE) && !(s1_vld_r && s1_last_r);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_vld_r;
  assign out_ch.norm_lane  = out_lane_r;
  assign out_ch.norm_value = out_norm_r;

  assign eps_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : eps_r;

  // magnitude of the sample; the most negative code gives 32768
  assign mag  = in_ch.sample[SAMPLE_W-1] ? (~{1'b1, in_ch.sample} + MAG_W'(1))
                                         : {1'b0, in_ch.sample};
  assign prod = mag * mag;
  assign s1_vld_nxt = in_fire;

  cl2n_ram #(.WIDTH(SUM_W), .DEPTH(LANES)) u_sum_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_lane_r),
    .wdata (wr_data),
    .raddr (in_ch.lane),
    .rdata (ram_rdata)
  );

  // read-modify-write; the previous cycle's write is forwarded past the RAM
  always_comb begin
    if (wb_vld_r && wb_lane_r == s1_lane_r) begin
      old_sum = wb_data_r;
    end else if (lane_vld_r[s1_lane_r]) begin
      old_sum = ram_rdata;
    end else begin
      old_sum = '0;
    end
    acc_wide = {1'b0, old_sum} + {{(SUM_W + 1 - SQ_W){1'b0}}, s1_sq_r};
    acc_sat  = acc_wide[SUM_W] ? SUM_MAX : acc_wide[SUM_W-1:0];
    wr_data  = s1_last_r ? '0 : acc_sat;
    wb_vld_nxt   = s1_vld_r;
    lane_vld_nxt = lane_vld_r;
    if (s1_vld_r) begin
      lane_vld_nxt[s1_lane_r] = 1'b1;
    end
  end

  always_comb begin
    sq_state_nxt = sq_state_r;
    sq_x_nxt     = sq_x_r;
    sq_lane_nxt  = sq_lane_r;
    sq_rem_nxt   = sq_rem_r;
    sq_root_nxt  = sq_root_r;
    sq_cnt_nxt   = sq_cnt_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_lane_nxt = out_lane_r;
    out_norm_nxt = out_norm_r;
    eps_wide     = {1'b0, sq_x_r} + {{(SUM_W + 1 - EPS_W){1'b0}}, eps_r};
    rem_sh       = {sq_rem_r[REM_W-3:0], sq_x_r[SUM_W-1 -: 2]};
    trial        = {{(REM_W - NORM_W - 2){1'b0}}, sq_root_r, 2'b01};
    unique case (sq_state_r)
      SQ_IDLE: begin
        if (s1_vld_r && s1_last_r) begin
          sq_x_nxt     = acc_sat;
          sq_lane_nxt  = s1_lane_r;
          sq_state_nxt = SQ_LOAD;
        end
      end
      SQ_LOAD: begin
        sq_x_nxt     = eps_wide[SUM_W] ? SUM_MAX : eps_wide[SUM_W-1:0];
        sq_rem_nxt   = '0;
        sq_root_nxt  = '0;
        sq_cnt_nxt   = '0;
        sq_state_nxt = SQ_ITER;
      end
      SQ_ITER: begin
        // one root bit per step, two radicand bits shifted in
        if (rem_sh >= trial) begin
          sq_rem_nxt  = rem_sh - trial;
          sq_root_nxt = {sq_root_r[NORM_W-2:0], 1'b1};
        end else begin
          sq_rem_nxt  = rem_sh;
          sq_root_nxt = {sq_root_r[NORM_W-2:0], 1'b0};
        end
        sq_x_nxt   = {sq_x_r[SUM_W-3:0], 2'b00};
        sq_cnt_nxt = sq_cnt_r + STEP_W'(1);
        if (sq_cnt_r == LAST_STEP) begin
          sq_state_nxt = SQ_DONE;
        end
      end
      SQ_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_lane_nxt = sq_lane_r;
          out_norm_nxt = sq_root_r;
          sq_state_nxt = SQ_IDLE;
        end
      end
      default: sq_state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r      <= EPS_RESET;
      s1_vld_r   <= 1'b0;
      wb_vld_r   <= 1'b0;
      lane_vld_r <= '0;
      sq_state_r <= SQ_IDLE;
      out_vld_r  <= 1'b0;
    end else begin
      eps_r      <= eps_nxt;
      s1_vld_r   <= s1_vld_nxt;
      wb_vld_r   <= wb_vld_nxt;
      lane_vld_r <= lane_vld_nxt;
      sq_state_r <= sq_state_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r <= in_ch.last_of_channel;
      s1_lane_r <= in_ch.lane;
      s1_sq_r   <= prod[SQ_W-1:0];
    end
    wb_lane_r  <= s1_lane_r;
    wb_data_r  <= wr_data;
    sq_x_r     <= sq_x_nxt;
    sq_lane_r  <= sq_lane_nxt;
    sq_rem_r   <= sq_rem_nxt;
    sq_root_r  <= sq_root_nxt;
    sq_cnt_r   <= sq_cnt_nxt;
    out_lane_r <= out_lane_nxt;
    out_norm_r <= out_norm_nxt;
  end

endmodule

FILE: hdl/cl2n_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module cl2n_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
